// ===== hdl/wcsa_pkg.sv =====
// shared types and constants for the wall clock source arbiter
package wcsa_pkg;

    // request codes carried in the low bits of the input tuser
    typedef enum logic [2:0] {
        REQ_RESTART = 3'd0,
        REQ_OFFER   = 3'd1,
        REQ_NOW     = 3'd2,
        REQ_PAST    = 3'd3,
        REQ_TICK    = 3'd4
    } t_req;

    // clock source codes
    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_STALE   = 2'd1;
    localparam logic [1:0] SRC_NETWORK = 2'd2;
    localparam logic [1:0] SRC_PHONE   = 2'd3;

    // stream widths
    localparam int unsigned IN_DATA_W  = 192;
    localparam int unsigned IN_USER_W  = 5;
    localparam int unsigned OUT_DATA_W = 128;
    localparam int unsigned OUT_USER_W = 6;

    // registered input item with the state-independent differences precomputed
    typedef struct packed {
        logic [2:0]  req;
        logic [1:0]  src;
        logic [63:0] tv;
        logic [63:0] up;
        logic [63:0] age;     // uptime - past_uptime
        logic [63:0] offset;  // time_value - uptime, the new anchor offset
    } t_item;

    // handshake between input stage and engine
    typedef struct packed {
        logic valid;
        logic take;
    } t_stage_ctl;

endpackage

// ===== hdl/wcsa_in_stage.sv =====
// input register stage: captures an item and precomputes its wrapped differences
module wcsa_in_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [wcsa_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  logic [wcsa_pkg::IN_USER_W-1:0]       i_s_tuser,
    input  logic                                 i_take,
    output logic                                 o_valid,
    output wcsa_pkg::t_item                      o_item
);

    logic            r_valid;
    wcsa_pkg::t_item r_item;
    wcsa_pkg::t_item n_item;
    logic            accept;

    // stage frees up when the engine takes its item
    assign o_s_tready = !r_valid || i_take;
    assign accept     = i_s_tvalid && o_s_tready;

    // unpack fields and form the differences
    always_comb begin
        n_item.req    = i_s_tuser[2:0];
        n_item.src    = i_s_tuser[4:3];
        n_item.tv     = i_s_tdata[63:0];
        n_item.up     = i_s_tdata[127:64];
        n_item.age    = i_s_tdata[127:64] - i_s_tdata[191:128];
        n_item.offset = i_s_tdata[63:0] - i_s_tdata[127:64];
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/wcsa_engine.sv =====
// clock state, per-request logic and result register
module wcsa_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_take,
    input  wcsa_pkg::t_item                      i_item,
    input  logic                                 i_cfg_wr,
    input  logic [31:0]                          i_cfg_data,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [wcsa_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic [wcsa_pkg::OUT_USER_W-1:0]      o_m_tuser
);

    // state: anchor kept as one offset, unix = uptime + offset
    logic [1:0]  r_source;
    logic [63:0] r_offset;
    logic [63:0] r_floor;
    logic [63:0] r_last_persist;
    logic [31:0] r_interval;
    logic        r_out_valid;
    logic [wcsa_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [wcsa_pkg::OUT_USER_W-1:0] r_out_user;

    logic [1:0]  n_source;
    logic [63:0] n_offset;
    logic [63:0] n_floor;
    logic [63:0] n_last_persist;

    logic        take;
    logic        out_free;
    logic [63:0] now_raw;
    logic [63:0] now_val;
    logic        offer_real;
    logic        offer_ok;
    logic        tick_due;
    logic        res_ok;
    logic [63:0] res_time;
    logic        res_swr;
    logic        res_fwr;
    logic [63:0] res_fval;
    logic        res_acq;

    assign out_free = !r_out_valid || i_m_tready;
    assign take     = i_in_valid && out_free;
    assign o_take   = take;

    // current wall time, raised to the floor
    assign now_raw = i_item.up + r_offset;
    assign now_val = (now_raw < r_floor) ? r_floor : now_raw;

    // offer acceptance and tick due check
    assign offer_real = (i_item.src == wcsa_pkg::SRC_NETWORK) ||
                        (i_item.src == wcsa_pkg::SRC_PHONE);
    assign offer_ok   = offer_real && !((r_source == wcsa_pkg::SRC_NETWORK) &&
                                        (i_item.src == wcsa_pkg::SRC_PHONE));
    assign tick_due   = (r_source != wcsa_pkg::SRC_NONE) &&
                        ((i_item.up - r_last_persist) >= {32'd0, r_interval});

    // request decode: next state and result fields
    always_comb begin
        n_source       = r_source;
        n_offset       = r_offset;
        n_floor        = r_floor;
        n_last_persist = r_last_persist;
        res_ok         = 1'b0;
        res_time       = 64'd0;
        res_swr        = 1'b0;
        res_fwr        = 1'b0;
        res_fval       = 64'd0;
        res_acq        = 1'b0;
        unique case (wcsa_pkg::t_req'(i_item.req))
            wcsa_pkg::REQ_RESTART: begin
                n_offset       = i_item.offset;
                n_last_persist = i_item.up;
                n_floor        = i_item.tv;
                n_source       = (i_item.tv != 64'd0) ? wcsa_pkg::SRC_STALE
                                                      : wcsa_pkg::SRC_NONE;
                res_swr        = 1'b1;
            end
            wcsa_pkg::REQ_OFFER: begin
                if (offer_ok) begin
                    res_acq  = !((r_source == wcsa_pkg::SRC_NETWORK) ||
                                 (r_source == wcsa_pkg::SRC_PHONE));
                    n_source = i_item.src;
                    n_offset = i_item.offset;
                    n_floor  = (i_item.tv > r_floor) ? i_item.tv : r_floor;
                    res_ok   = 1'b1;
                    res_swr  = 1'b1;
                    res_fwr  = 1'b1;
                    res_fval = n_floor;
                end
            end
            wcsa_pkg::REQ_NOW: begin
                if (r_source != wcsa_pkg::SRC_NONE) begin
                    res_ok   = 1'b1;
                    res_time = now_val;
                end
            end
            wcsa_pkg::REQ_PAST: begin
                if (r_source != wcsa_pkg::SRC_NONE) begin
                    res_ok   = 1'b1;
                    res_time = (now_val > i_item.age) ? (now_val - i_item.age) : 64'd0;
                end
            end
            wcsa_pkg::REQ_TICK: begin
                if (tick_due) begin
                    n_floor        = now_val;
                    n_last_persist = i_item.up;
                    res_fwr        = 1'b1;
                    res_fval       = now_val;
                end
            end
            default: begin
                // unused request codes leave everything alone
            end
        endcase
    end

    // control state and clock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source       <= wcsa_pkg::SRC_NONE;
            r_offset       <= 64'd0;
            r_floor        <= 64'd0;
            r_last_persist <= 64'd0;
            r_interval     <= 32'd60000;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_interval <= i_cfg_data;
            end
            if (take) begin
                r_source       <= n_source;
                r_offset       <= n_offset;
                r_floor        <= n_floor;
                r_last_persist <= n_last_persist;
                r_out_valid    <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= {res_fval, res_time};
            r_out_user <= {res_acq, res_fwr, res_swr, n_source, res_ok};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// ===== hdl/wall_clock_source_arbiter_core.sv =====
// top level of the wall clock source arbiter
//
// Keeps a wall clock in unix milliseconds anchored to monotonic uptime and
// arbitrates between network and phone time sources.
// Input channel (s side): one request item per handshake; tuser carries the
// request code and the offered source, tdata the time value, the uptime and
// the past uptime.
// Output channel (m side): exactly one result item per request, in order;
// tuser carries the status flags and current source, tdata the answered time
// and the floor value to persist.
// Config channel: a write sets the persist interval (60000 ms after reset);
// write it only while no request is in flight.
// The input handshake loads the input register, and the engine then loads the
// result register when it is free. Throughput: one item per cycle while the
// receiver is ready; the 64-bit add, compare and subtract path is combinational.
// Reset (synchronous, active low) clears the source to none, the anchor,
// floor and persist uptime to zero, and empties both registers.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; after that the input tready drops.
module wall_clock_source_arbiter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: time_value[63:0], uptime[127:64], past_uptime[191:128]
    input  logic [wcsa_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // tuser: req_type[2:0], offered_source[4:3]
    input  logic [wcsa_pkg::IN_USER_W-1:0]       i_s_tuser,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: time_out[63:0], floor_value[127:64]
    output logic [wcsa_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // tuser: ok[0], current_source[2:1], source_write[3], floor_write[4],
    //        acquired[5]
    output logic [wcsa_pkg::OUT_USER_W-1:0]      o_m_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [31:0]                          i_cfg_data
);

    logic                 stage_valid;
    logic                 take;
    wcsa_pkg::t_item      stage_item;
    wcsa_pkg::t_stage_ctl stage_ctl;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    assign stage_ctl.valid = stage_valid;
    assign stage_ctl.take  = take;

    // input register
    wcsa_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_take     (stage_ctl.take),
        .o_valid    (stage_valid),
        .o_item     (stage_item)
    );

    // state and result register
    wcsa_engine u_eng (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (stage_ctl.valid),
        .o_take     (take),
        .i_item     (stage_item),
        .i_cfg_wr   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== hdl/wcsa_checker.sv =====
// port-level checks for the wall clock source arbiter, bound to the top level
module wcsa_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [wcsa_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  logic [wcsa_pkg::OUT_USER_W-1:0]      o_m_tuser,
    input  logic                                 o_m_tvalid,
    input  logic                                 i_m_tready
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
                                      $stable(o_m_tuser))
        else $error("stalled result changed");

    // acquisition only comes with an accepted offer
    a_acq_offer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[5] |-> o_m_tuser[0] && o_m_tuser[3] && o_m_tuser[4] &&
                                       o_m_tuser[2])
        else $error("acquired without accepted real offer");

    // unanswered items carry no time
    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[63:0] == 64'd0)
        else $error("time out nonzero without ok");

    // floor value only when a floor write is asked for
    a_floor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[4] |-> o_m_tdata[127:64] == 64'd0)
        else $error("floor value nonzero without floor write");

endmodule

bind wall_clock_source_arbiter_core wcsa_checker u_wcsa_checker (.*);
